[rtl/core/rttsa_pkg.sv]
`default_nettype none

package rttsa_pkg;

   // Fixed widths of the word fields
   localparam int RTT_W     = 20;
   localparam int CNT_OUT_W = 24;
   localparam int LOSS_W    = 14;

   // Loss is given in hundredths of a percent: full scale is 100.00 %
   localparam int LOSS_SCALE = 10000;

   // Defaults for the top-level parameters
   localparam int COUNT_BITS_DEF   = 24;
   localparam int RTT_LIMIT_US_DEF = 1000000;

   typedef enum logic [1:0] {
      EV_SENT   = 2'd0,
      EV_REPLY  = 2'd1,
      EV_REPORT = 2'd2,
      EV_CLEAR  = 2'd3
   } event_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AVG_GO,
      S_AVG_WAIT,
      S_MSQ_GO,
      S_MSQ_WAIT,
      S_ROOT_GO,
      S_LOSS_GO,
      S_LOSS_WAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      event_type          req_type;
      logic [RTT_W-1:0]   rtt_us;
   } req_word_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] sent_total;
      logic [CNT_OUT_W-1:0] recv_total;
      logic [RTT_W-1:0]     rtt_min_us;
      logic [RTT_W-1:0]     rtt_max_us;
      logic [RTT_W-1:0]     rtt_avg_us;
      logic [RTT_W-1:0]     rtt_mdev_us;
      logic [LOSS_W-1:0]    loss_hundredths;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/core/rttsa_serial_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rttsa_serial_div #(
   parameter int DIVIDEND_W = 64,
   parameter int DIVISOR_W  = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import rttsa_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  take;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, div_ff};
      take  = (trial >= {1'b0, div_ff});
   end

   // Dividend shifts out at the top while quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], take};
         rem_ff <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(DIVIDEND_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/rttsa_isqrt.sv]
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module rttsa_isqrt #(
   parameter int ROOT_W = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]          root
);
   import rttsa_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic [ROOT_W+3:0]   rem_sh;
   logic [ROOT_W+3:0]   trial;
   logic [ROOT_W+3:0]   diff;
   logic                take;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      diff   = rem_sh - trial;
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff  <= {rad_ff[2*ROOT_W-3:0], 2'b00};
         rem_ff  <= take ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Root holds once the last digit is in
   assign root = root_ff;

endmodule

`default_nettype wire

[rtl/core/rtt_statistics_accumulator.sv]
// Sent, reply and clear words: one per cycle while no report is in progress, no result word.
// Report word: result on rsp after three passes of the shared bit-serial divider
//   (average, mean square, loss) with the root alongside; req stalls meanwhile.
// The result sits in an output register, so traffic resumes while it waits on rsp.
// Synchronous reset: counts, sums and max to zero, min to all ones, no word pending.
`default_nettype none

module rtt_statistics_accumulator #(
   parameter int COUNT_BITS   = rttsa_pkg::COUNT_BITS_DEF,
   parameter int RTT_LIMIT_US = rttsa_pkg::RTT_LIMIT_US_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rttsa_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rttsa_pkg::rsp_word_type     rsp_data
);
   import rttsa_pkg::*;

   // Sum of RTTs and sum of squares cannot overflow: replies stop counting at full scale
   localparam int SUM_W = COUNT_BITS + RTT_W;
   localparam int SQ_W  = COUNT_BITS + 2 * RTT_W;
   localparam int DIV_W = SQ_W;
   localparam int NUM_W = COUNT_BITS + LOSS_W;

   localparam logic [RTT_W-1:0]      RTT_LIMIT = RTT_W'(RTT_LIMIT_US);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Statistics
   logic [COUNT_BITS-1:0] sent_ff;
   logic [COUNT_BITS-1:0] recv_ff;
   logic [RTT_W-1:0]      min_ff;
   logic [RTT_W-1:0]      max_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SQ_W-1:0]       sq_sum_ff;

   // Square of the last reply, folded into the sum in the following cycle
   logic [2*RTT_W-1:0]    sq_ff;
   logic [2*RTT_W-1:0]    sq_in;
   logic                  sq_pend_ff;

   // Report working registers
   state_type             state_ff;
   state_type             state_in;
   logic [RTT_W-1:0]      avg_ff;
   logic [2*RTT_W-1:0]    avg_sq_ff;
   logic [2*RTT_W-1:0]    msq_ff;
   logic [NUM_W-1:0]      loss_num_ff;
   logic [LOSS_W-1:0]     loss_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_data_ff;
   rsp_word_type          rsp_in;

   logic                  req_fire;
   logic                  sent_take;
   logic                  reply_take;
   logic                  clear_take;
   logic [RTT_W-1:0]      rtt_clamped;
   logic                  has_recv;
   logic                  loss_ok;
   logic                  out_free;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quotient;

   logic                  root_start;
   logic [2*RTT_W-1:0]    root_radicand;
   logic [RTT_W-1:0]      root_value;

   // ---------------------------------------------------------------------
   // Event decode: words are taken only in the idle state
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      sent_take  = 1'b0;
      reply_take = 1'b0;
      clear_take = 1'b0;
      case (req_data.req_type)
         EV_SENT:   sent_take  = req_fire && (sent_ff != COUNT_MAX);
         // A reply is dropped entirely once the receive counter is full
         EV_REPLY:  reply_take = req_fire && (recv_ff != COUNT_MAX);
         EV_CLEAR:  clear_take = req_fire;
         default:   ;
      endcase
   end

   assign rtt_clamped = (req_data.rtt_us > RTT_LIMIT) ? RTT_LIMIT : req_data.rtt_us;
   assign sq_in       = (2*RTT_W)'(rtt_clamped) * (2*RTT_W)'(rtt_clamped);

   // ---------------------------------------------------------------------
   // Statistics update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || clear_take) begin
         sent_ff    <= '0;
         recv_ff    <= '0;
         min_ff     <= '1;
         max_ff     <= '0;
         sum_ff     <= '0;
         sq_sum_ff  <= '0;
         sq_pend_ff <= 1'b0;
      end else begin
         // Fold the square registered last cycle
         if (sq_pend_ff) begin
            sq_sum_ff <= sq_sum_ff + SQ_W'(sq_ff);
         end
         sq_pend_ff <= reply_take;
         if (sent_take) begin
            sent_ff <= sent_ff + 1'b1;
         end
         if (reply_take) begin
            recv_ff <= recv_ff + 1'b1;
            sum_ff  <= sum_ff + SUM_W'(rtt_clamped);
            if (rtt_clamped < min_ff) begin
               min_ff <= rtt_clamped;
            end
            if (rtt_clamped > max_ff) begin
               max_ff <= rtt_clamped;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reply_take) begin
         sq_ff <= sq_in;
      end
   end

   // ---------------------------------------------------------------------
   // Report sequencer: average, mean square, root of variance, loss
   // ---------------------------------------------------------------------
   assign has_recv = (recv_ff != '0);
   assign loss_ok  = (sent_ff != '0) && (recv_ff <= sent_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = recv_ff;
      root_start    = 1'b0;
      root_radicand = (msq_ff > avg_sq_ff) ? (msq_ff - avg_sq_ff) : '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.req_type == EV_REPORT)) begin
               state_in = S_AVG_GO;
            end
         end
         S_AVG_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sum_ff);
            state_in     = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_done) begin
               state_in = S_MSQ_GO;
            end
         end
         S_MSQ_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sq_sum_ff);
            state_in     = S_MSQ_WAIT;
         end
         S_MSQ_WAIT: begin
            if (div_done) begin
               state_in = S_ROOT_GO;
            end
         end
         S_ROOT_GO: begin
            // Root runs alongside the loss division, which is always longer
            root_start = 1'b1;
            state_in   = S_LOSS_GO;
         end
         S_LOSS_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(loss_num_ff);
            div_divisor  = sent_ff;
            state_in     = S_LOSS_WAIT;
         end
         S_LOSS_WAIT: begin
            div_divisor = sent_ff;
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the output register is free
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Intermediate results
   always_ff @(posedge clock) begin
      if ((state_ff == S_AVG_WAIT) && div_done) begin
         avg_ff <= div_quotient[RTT_W-1:0];
      end
      if (state_ff == S_MSQ_GO) begin
         avg_sq_ff <= (2*RTT_W)'(avg_ff) * (2*RTT_W)'(avg_ff);
      end
      if ((state_ff == S_MSQ_WAIT) && div_done) begin
         msq_ff <= div_quotient[2*RTT_W-1:0];
      end
      if (state_ff == S_ROOT_GO) begin
         loss_num_ff <= NUM_W'(sent_ff - recv_ff) * NUM_W'(LOSS_SCALE);
      end
      if ((state_ff == S_LOSS_WAIT) && div_done) begin
         loss_ff <= div_quotient[LOSS_W-1:0];
      end
   end

   rttsa_serial_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rttsa_isqrt #(
      .ROOT_W (RTT_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_radicand),
      .root     (root_value)
   );

   // ---------------------------------------------------------------------
   // Output register: RTT figures drop to zero with no replies
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in.sent_total      = CNT_OUT_W'(sent_ff);
      rsp_in.recv_total      = CNT_OUT_W'(recv_ff);
      rsp_in.rtt_min_us      = has_recv ? min_ff : '0;
      rsp_in.rtt_max_us      = has_recv ? max_ff : '0;
      rsp_in.rtt_avg_us      = has_recv ? avg_ff : '0;
      rsp_in.rtt_mdev_us     = has_recv ? root_value : '0;
      rsp_in.loss_hundredths = loss_ok ? loss_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      clear_take |=> (sent_ff == '0) && (recv_ff == '0) && !sq_pend_ff && (sum_ff == '0))
      else $error("clear left statistics behind");

   a_recv_monotone : assert property (@(posedge clock) disable iff (reset)
      !clear_take |=> (recv_ff >= $past(recv_ff)))
      else $error("receive count went backwards");

   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      has_recv |-> (min_ff <= max_ff))
      else $error("min above max with replies counted");

   a_rsp_from_report : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result word raised outside the report path");

   a_stats_frozen : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) && !sq_pend_ff |=> $stable(sq_sum_ff) && $stable(sum_ff))
      else $error("sums changed during a report");

endmodule

`default_nettype wire
